>>> rtl/core/assert_macros.svh
// assertion macros for the files that check themselves
// depends on nothing; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold at every clock edge where ante holds, outside reset
`define DWSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define DWSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dwsr_pkg.sv
// shared widths, operation and status codes, command kinds for the deque
// depends on nothing
package dwsr_pkg;

  localparam int DATA_W         = 32;
  localparam int OP_W           = 3;
  localparam int STAT_W         = 2;
  localparam int COUNT_W        = 5;
  localparam int DEPTH_DEF      = 16;
  localparam int CMDQ_DEPTH_DEF = 4;

  localparam logic [OP_W-1:0] OP_CREATE     = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd4;
  localparam logic [OP_W-1:0] OP_SORT       = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ,
    CMD_SORT
  } cmd_kind_t;

  typedef struct packed {
    logic sort_active;
    logic read_pending;
  } back_stat_t;

endpackage

>>> rtl/core/dwsr_in_if.sv
// input channel: valid/ready handshake carrying op and value
// depends on dwsr_pkg
interface dwsr_in_if import dwsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

>>> rtl/core/dwsr_out_if.sv
// result channel: valid/ready handshake carrying one result word
// depends on dwsr_pkg
interface dwsr_out_if import dwsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       element_count;
  logic                     last;

  modport source (output valid, output data_out, output status, output element_count,
                  output last, input ready);
  modport sink (input valid, input data_out, input status, input element_count,
                input last, output ready);
endinterface

>>> rtl/core/dwsr_ram.sv
// generic single-write, single-read RAM with registered read data
// depends on nothing
module dwsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/dwsr_cmd_q.sv
// small fifo of classified commands between front and back
// depends on dwsr_pkg
module dwsr_cmd_q import dwsr_pkg::*; #(
  parameter int WIDTH = 40,
  parameter int DEPTH = CMDQ_DEPTH_DEF,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != FULL_C);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/dwsr_front.sv
// front end: accepts ops, keeps front index and count, emits commands
// depends on dwsr_pkg, dwsr_in_if
module dwsr_front import dwsr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int CMD_W = $bits(cmd_kind_t) + IDX_W + DATA_W + STAT_W + CNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  dwsr_in_if.sink          in_ch,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [CMD_W-1:0] q_data
);

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(DEPTH);

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              accept;
  logic [CNT_W:0]    sum_back, sum_last, tail_w, last_w;
  logic [IDX_W-1:0]  push_slot, pop_slot, front_dec, front_inc;
  cmd_kind_t         kind;
  logic [IDX_W-1:0]  addr;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  count;

  assign in_ch.ready = q_ready;
  assign q_valid     = in_ch.valid;
  assign accept      = in_ch.valid && q_ready;

  // slots of the element past the back and of the back element itself
  assign sum_back  = {1'b0, total_r} + (CNT_W + 1)'(front_r);
  assign sum_last  = sum_back - (CNT_W + 1)'(1);
  assign tail_w    = (sum_back >= DEPTH_S) ? sum_back - DEPTH_S : sum_back;
  assign last_w    = (sum_last >= DEPTH_S) ? sum_last - DEPTH_S : sum_last;
  assign push_slot = tail_w[IDX_W-1:0];
  assign pop_slot  = last_w[IDX_W-1:0];
  assign front_dec = (front_r == '0) ? IDX_MAX : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_MAX) ? '0 : front_r + IDX_W'(1);

  always_comb begin
    front_nxt = front_r;
    total_nxt = total_r;
    kind      = CMD_NONE;
    addr      = '0;
    status    = STAT_OK;
    count     = total_r;
    case (in_ch.op)
      OP_CREATE: begin
        front_nxt = '0;
        total_nxt = CNT_W'(1);
        kind      = CMD_WRITE;
        count     = CNT_W'(1);
      end
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (total_r == '0) begin
          status = STAT_EMPTY;
        end else if (total_r >= DEPTH_C) begin
          status = STAT_FULL;
        end else begin
          total_nxt = total_r + CNT_W'(1);
          count     = total_nxt;
          kind      = CMD_WRITE;
          if (in_ch.op == OP_PUSH_BACK) begin
            addr = push_slot;
          end else begin
            front_nxt = front_dec;
            addr      = front_dec;
          end
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (total_r == '0) begin
          status = STAT_EMPTY;
        end else begin
          total_nxt = total_r - CNT_W'(1);
          count     = total_nxt;
          kind      = CMD_READ;
          if (in_ch.op == OP_POP_BACK) begin
            addr = pop_slot;
          end else begin
            addr      = front_r;
            front_nxt = front_inc;
          end
          // an emptied deque restarts at slot zero
          if (total_nxt == '0) begin
            front_nxt = '0;
          end
        end
      end
      OP_SORT: begin
        if (total_r == '0) begin
          status = STAT_EMPTY;
        end else begin
          kind = CMD_SORT;
          addr = front_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign q_data = {kind, addr, in_ch.value, status, count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      total_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

>>> rtl/core/dwsr_back.sv
// back end: executes commands on the element ram, runs the insertion
// sorter and drives the result register; depends on dwsr_pkg, dwsr_out_if, dwsr_ram
module dwsr_back import dwsr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int CMD_W = $bits(cmd_kind_t) + IDX_W + DATA_W + STAT_W + CNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [CMD_W-1:0] q_data,
  dwsr_out_if.source       out_ch,
  output back_stat_t       stat
);

  localparam int KIND_W = $bits(cmd_kind_t);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_RUN,
    S_SORT_RD,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic              a_valid_r, a_valid_nxt, a_read_r, a_read_nxt;
  logic [STAT_W-1:0] a_status_r, a_status_nxt;
  logic [CNT_W-1:0]  a_count_r, a_count_nxt;

  logic                     out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]       out_count_r, out_count_nxt;

  logic [CNT_W-1:0] rd_off_r, rd_off_nxt, sort_n_r, sort_n_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt, rem_r, rem_nxt;
  logic [IDX_W-1:0] rd_slot_r, rd_slot_nxt;
  logic             ins_pend_r, ins_pend_nxt;

  logic signed [DATA_W-1:0] cell_r [DEPTH];
  logic signed [DATA_W-1:0] cell_nxt [DEPTH];
  logic signed [DATA_W-1:0] ins_row [DEPTH];
  logic signed [DATA_W-1:0] shf_row [DEPTH];
  logic [DEPTH-1:0]         h;

  cmd_kind_t                q_kind;
  logic [IDX_W-1:0]         q_addr;
  logic signed [DATA_W-1:0] q_value;
  logic [STAT_W-1:0]        q_status;
  logic [CNT_W-1:0]         q_count;

  logic                     q_pop, out_free, a_adv, rd_issue;
  logic                     ram_we, ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic signed [DATA_W-1:0] ram_rdata;
  logic [CNT_W+COUNT_W-1:0] a_count_ext, sort_n_ext;

  assign q_count  = q_data[CNT_W-1:0];
  assign q_status = q_data[CNT_W +: STAT_W];
  assign q_value  = q_data[CNT_W+STAT_W +: DATA_W];
  assign q_addr   = q_data[CNT_W+STAT_W+DATA_W +: IDX_W];
  assign q_kind   = cmd_kind_t'(q_data[CMD_W-1 -: KIND_W]);

  assign out_free = !out_valid_r || out_ch.ready;
  assign a_adv    = a_valid_r && out_free;
  assign q_ready  = (state_r == S_RUN) && (!a_valid_r || a_adv);
  assign q_pop    = q_valid && q_ready;
  assign rd_issue = (state_r == S_SORT_RD) && (rd_off_r < sort_n_r);

  assign ram_we    = q_pop && (q_kind == CMD_WRITE);
  assign ram_re    = (q_pop && (q_kind == CMD_READ)) || rd_issue;
  assign ram_raddr = (state_r == S_SORT_RD) ? rd_slot_r : q_addr;

  dwsr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_addr),
    .wdata (q_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign a_count_ext = {{COUNT_W{1'b0}}, a_count_r};
  assign sort_n_ext  = {{COUNT_W{1'b0}}, sort_n_r};

  // insertion cells: h marks cells that hold a larger value or are unfilled
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      h[k] = (CNT_W'(k) >= fill_r) || (cell_r[k] > ram_rdata);
    end
    ins_row[0] = h[0] ? ram_rdata : cell_r[0];
    for (int k = 1; k < DEPTH; k++) begin
      ins_row[k] = h[k-1] ? cell_r[k-1] : (h[k] ? ram_rdata : cell_r[k]);
    end
    for (int k = 0; k < DEPTH - 1; k++) begin
      shf_row[k] = cell_r[k+1];
    end
    shf_row[DEPTH-1] = cell_r[DEPTH-1];
  end

  always_comb begin
    state_nxt      = state_r;
    a_valid_nxt    = a_valid_r;
    a_read_nxt     = a_read_r;
    a_status_nxt   = a_status_r;
    a_count_nxt    = a_count_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    rd_off_nxt     = rd_off_r;
    rd_slot_nxt    = rd_slot_r;
    sort_n_nxt     = sort_n_r;
    fill_nxt       = fill_r;
    rem_nxt        = rem_r;
    ins_pend_nxt   = ins_pend_r;
    for (int k = 0; k < DEPTH; k++) begin
      cell_nxt[k] = cell_r[k];
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (a_adv) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = a_read_r ? ram_rdata : '0;
      out_status_nxt = a_status_r;
      out_count_nxt  = a_count_ext[COUNT_W-1:0];
      out_last_nxt   = 1'b1;
      a_valid_nxt    = 1'b0;
    end

    case (state_r)
      S_RUN: begin
        if (q_pop) begin
          if (q_kind == CMD_SORT) begin
            state_nxt    = S_SORT_RD;
            rd_off_nxt   = '0;
            rd_slot_nxt  = q_addr;
            sort_n_nxt   = q_count;
            fill_nxt     = '0;
            ins_pend_nxt = 1'b0;
          end else begin
            a_valid_nxt  = 1'b1;
            a_read_nxt   = (q_kind == CMD_READ);
            a_status_nxt = q_status;
            a_count_nxt  = q_count;
          end
        end
      end
      S_SORT_RD: begin
        // read of element i overlaps the insertion of element i-1
        ins_pend_nxt = rd_issue;
        if (rd_issue) begin
          rd_off_nxt  = rd_off_r + CNT_W'(1);
          rd_slot_nxt = (rd_slot_r == IDX_MAX) ? '0 : rd_slot_r + IDX_W'(1);
        end
        if (ins_pend_r) begin
          for (int k = 0; k < DEPTH; k++) begin
            cell_nxt[k] = ins_row[k];
          end
          fill_nxt = fill_r + CNT_W'(1);
          if (fill_r + CNT_W'(1) == sort_n_r) begin
            state_nxt = S_EMIT;
            rem_nxt   = sort_n_r;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = cell_r[0];
          out_status_nxt = STAT_OK;
          out_count_nxt  = sort_n_ext[COUNT_W-1:0];
          out_last_nxt   = (rem_r == CNT_W'(1));
          for (int k = 0; k < DEPTH; k++) begin
            cell_nxt[k] = shf_row[k];
          end
          rem_nxt = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_RUN;
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_read_r     <= a_read_nxt;
    a_status_r   <= a_status_nxt;
    a_count_r    <= a_count_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    rd_slot_r    <= rd_slot_nxt;
    sort_n_r     <= sort_n_nxt;
    for (int k = 0; k < DEPTH; k++) begin
      cell_r[k] <= cell_nxt[k];
    end
    if (!rst_n) begin
      state_r     <= S_RUN;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rd_off_r    <= '0;
      fill_r      <= '0;
      rem_r       <= '0;
      ins_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rd_off_r    <= rd_off_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      ins_pend_r  <= ins_pend_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_out      = out_data_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.last          = out_last_r;

  assign stat.sort_active  = (state_r != S_RUN);
  assign stat.read_pending = a_valid_r;

endmodule

>>> rtl/core/deque_with_sorted_readout.sv
// bounded deque with sorted readout: create, push and pop give one result word
// each, through the command queue, back stage and output register, one per cycle
// while results are taken; sort of n elements reads the ram into the insertion
// cells, then gives n output words while later ops wait in the 4-entry command
// queue; synchronous active-low reset clears index, count, queue and pipeline, not the element ram
`include "assert_macros.svh"

module deque_with_sorted_readout import dwsr_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int QUEUE_DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dwsr_in_if.sink    in_ch,
  dwsr_out_if.source out_ch
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = $bits(cmd_kind_t) + IDX_W + DATA_W + STAT_W + CNT_W;

  logic             fq_valid, fq_ready, qb_valid, qb_ready;
  logic [CMD_W-1:0] fq_data, qb_data;
  back_stat_t       bstat;

  dwsr_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_data  (fq_data)
  );

  dwsr_cmd_q #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  dwsr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_data  (qb_data),
    .out_ch  (out_ch),
    .stat    (bstat)
  );

  // an accepted word is waiting in the queue on the next cycle
  `DWSR_ASSERT_NEXT(a_accept_queued, clk, rst_n, in_ch.valid && in_ch.ready, qb_valid, "accepted word not queued")
  // no command leaves the queue while a sort owns the ram and cells
  `DWSR_ASSERT_NOW(a_sort_holds_queue, clk, rst_n, bstat.sort_active, !(qb_valid && qb_ready), "queue popped during sort")
  `DWSR_ASSERT_NOW(a_sort_no_pending, clk, rst_n, bstat.sort_active, !bstat.read_pending, "result pending during sort")
  // sorted run goes out without gaps once a word is taken
  `DWSR_ASSERT_NEXT(a_run_no_gap, clk, rst_n, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid, "gap inside sorted run")

endmodule
